// File: rtl/core/mtsf_pkg.sv
// ----------------------------------------------------------------------------
// mtsf_pkg: shared definitions for the multi-term substring filter
// Sizes, codes, types and the case-folding function used by the loader,
// the matcher, the configuration registers and the top level.
// ----------------------------------------------------------------------------
package mtsf_pkg;

  localparam int MAX_TERMS    = 8;
  localparam int MAX_TERM_LEN = 32;

  localparam int TOT_W  = $clog2(MAX_TERMS + 1);
  localparam int TIDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int LEN_W  = $clog2(MAX_TERM_LEN + 1);
  localparam int POS_W  = (MAX_TERM_LEN > 1) ? $clog2(MAX_TERM_LEN) : 1;

  localparam int ADDR_W = 3;

  localparam logic [1:0] KIND_FILTER = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic REG_COMBINE_MODE  = 1'b0;
  localparam logic REG_INVERT_RESULT = 1'b1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef logic [MAX_TERM_LEN-1:0][7:0]         term_row_t;
  typedef term_row_t [MAX_TERMS-1:0]            term_store_t;
  typedef logic [MAX_TERMS-1:0][LEN_W-1:0]      term_len_t;
  typedef logic [MAX_TERM_LEN-1:0]              prefix_t;

  typedef struct packed {
    logic combine_mode;
    logic invert_result;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       clear;
    logic       last;
    logic [7:0] data;
  } step_cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mtsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// mtsf_cfg_regs: configuration registers
// APB-style register file holding the combine mode and the invert setting.
// ----------------------------------------------------------------------------
module mtsf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtsf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mtsf_pkg::cfg_t              cfg
);

  mtsf_pkg::cfg_t cfg_r;
  mtsf_pkg::cfg_t cfg_nxt;
  logic           reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[mtsf_pkg::ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        mtsf_pkg::REG_COMBINE_MODE:  cfg_nxt.combine_mode  = pwdata[0];
        mtsf_pkg::REG_INVERT_RESULT: cfg_nxt.invert_result = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtsf_pkg::REG_COMBINE_MODE:  prdata = {31'd0, cfg_r.combine_mode};
      mtsf_pkg::REG_INVERT_RESULT: prdata = {31'd0, cfg_r.invert_result};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/mtsf_loader.sv
// ----------------------------------------------------------------------------
// mtsf_loader: filter term loader and term storage
// Splits filter bytes into terms, stores the case-folded term bytes and
// tracks term lengths, the term count and the overflow condition.
// ----------------------------------------------------------------------------
module mtsf_loader (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtsf_pkg::step_cmd_t         cmd,
  output mtsf_pkg::term_store_t       term_bytes,
  output mtsf_pkg::term_len_t         term_len,
  output logic [mtsf_pkg::TOT_W-1:0]  term_total,
  output logic                        overflow
);

  mtsf_pkg::term_store_t            term_bytes_r;
  mtsf_pkg::term_len_t              term_len_r;
  mtsf_pkg::term_len_t              term_len_nxt;
  logic [mtsf_pkg::TOT_W-1:0]       total_r;
  logic [mtsf_pkg::TOT_W-1:0]       total_nxt;
  logic [mtsf_pkg::TOT_W-1:0]       total_m1;
  logic                             gap_r;
  logic                             gap_nxt;
  logic                             ovf_r;
  logic                             ovf_nxt;
  logic [mtsf_pkg::TIDX_W-1:0]      cur_idx;
  logic [mtsf_pkg::LEN_W-1:0]       cur_len;
  logic                             room;
  logic                             is_space;
  logic                             wr_en;
  logic [mtsf_pkg::POS_W-1:0]       wr_pos;
  logic [7:0]                       wr_data;

  assign term_bytes = term_bytes_r;
  assign term_len   = term_len_r;
  assign term_total = total_r;
  assign overflow   = ovf_r;

  assign total_m1 = total_r - mtsf_pkg::TOT_W'(1);
  assign cur_idx  = gap_r ? total_r[mtsf_pkg::TIDX_W-1:0] : total_m1[mtsf_pkg::TIDX_W-1:0];
  assign cur_len  = term_len_r[cur_idx];
  assign room     = total_r < mtsf_pkg::TOT_W'(mtsf_pkg::MAX_TERMS);
  assign is_space = (cmd.data == mtsf_pkg::CHAR_SPACE) || (cmd.data == mtsf_pkg::CHAR_TAB);
  assign wr_data  = mtsf_pkg::fold_case(cmd.data);

  always_comb begin
    total_nxt    = total_r;
    gap_nxt      = gap_r;
    ovf_nxt      = ovf_r;
    term_len_nxt = term_len_r;
    wr_en        = 1'b0;
    wr_pos       = '0;
    if (cmd.clear) begin
      total_nxt    = '0;
      gap_nxt      = 1'b1;
      ovf_nxt      = 1'b0;
      term_len_nxt = '0;
    end else if (cmd.load && (cmd.data != mtsf_pkg::CHAR_NUL)) begin
      if (is_space) begin
        gap_nxt = 1'b1;
      end else if (gap_r) begin
        if (!room) begin
          ovf_nxt = 1'b1;
        end else begin
          total_nxt             = total_r + mtsf_pkg::TOT_W'(1);
          gap_nxt               = 1'b0;
          term_len_nxt[cur_idx] = mtsf_pkg::LEN_W'(1);
          wr_en                 = 1'b1;
          wr_pos                = '0;
        end
      end else if (cur_len >= mtsf_pkg::LEN_W'(mtsf_pkg::MAX_TERM_LEN)) begin
        ovf_nxt = 1'b1;
      end else begin
        term_len_nxt[cur_idx] = cur_len + mtsf_pkg::LEN_W'(1);
        wr_en                 = 1'b1;
        wr_pos                = cur_len[mtsf_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      gap_r      <= 1'b1;
      ovf_r      <= 1'b0;
      term_len_r <= '0;
    end else begin
      total_r    <= total_nxt;
      gap_r      <= gap_nxt;
      ovf_r      <= ovf_nxt;
      term_len_r <= term_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      term_bytes_r[cur_idx][wr_pos] <= wr_data;
    end
  end

endmodule

// File: rtl/core/mtsf_matcher.sv
// ----------------------------------------------------------------------------
// mtsf_matcher: parallel substring matcher
// Compares each text byte against every stored term position at once,
// advances the per-term prefix vectors and forms the combined verdict.
// ----------------------------------------------------------------------------
module mtsf_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mtsf_pkg::step_cmd_t         cmd,
  input  mtsf_pkg::cfg_t              cfg,
  input  mtsf_pkg::term_store_t       term_bytes,
  input  mtsf_pkg::term_len_t         term_len,
  input  logic [mtsf_pkg::TOT_W-1:0]  term_total,
  output logic                        matched
);

  mtsf_pkg::prefix_t [mtsf_pkg::MAX_TERMS-1:0] prefix_r;
  mtsf_pkg::prefix_t [mtsf_pkg::MAX_TERMS-1:0] prefix_scan;
  mtsf_pkg::prefix_t [mtsf_pkg::MAX_TERMS-1:0] prefix_nxt;
  mtsf_pkg::prefix_t [mtsf_pkg::MAX_TERMS-1:0] eq;
  mtsf_pkg::prefix_t [mtsf_pkg::MAX_TERMS-1:0] step_vec;
  logic [mtsf_pkg::MAX_TERMS-1:0][mtsf_pkg::LEN_W-1:0] len_m1;
  logic [mtsf_pkg::MAX_TERMS-1:0] found_r;
  logic [mtsf_pkg::MAX_TERMS-1:0] found_scan;
  logic [mtsf_pkg::MAX_TERMS-1:0] found_nxt;
  logic [mtsf_pkg::MAX_TERMS-1:0] active;
  logic [mtsf_pkg::MAX_TERMS-1:0] mask;
  logic [7:0]                     c;
  logic                           hit;

  assign c = mtsf_pkg::fold_case(cmd.data);

  always_comb begin
    for (int t = 0; t < mtsf_pkg::MAX_TERMS; t++) begin
      mask[t]   = mtsf_pkg::TOT_W'(t) < term_total;
      active[t] = mask[t] && (term_len[t] != '0);
      len_m1[t] = term_len[t] - mtsf_pkg::LEN_W'(1);
      for (int i = 0; i < mtsf_pkg::MAX_TERM_LEN; i++) begin
        eq[t][i] = (mtsf_pkg::LEN_W'(i) < term_len[t]) && (term_bytes[t][i] == c);
      end
      step_vec[t] = ((prefix_r[t] << 1) | mtsf_pkg::MAX_TERM_LEN'(1)) & eq[t];
      if (active[t]) begin
        prefix_scan[t] = step_vec[t];
        found_scan[t]  = found_r[t] | step_vec[t][len_m1[t][mtsf_pkg::POS_W-1:0]];
      end else begin
        prefix_scan[t] = prefix_r[t];
        found_scan[t]  = found_r[t];
      end
    end
  end

  always_comb begin
    if (term_total == '0) begin
      hit = 1'b1;
    end else if (cfg.combine_mode) begin
      hit = |(found_scan & mask);
    end else begin
      hit = &(found_scan | ~mask);
    end
    matched = hit ^ cfg.invert_result;
  end

  always_comb begin
    prefix_nxt = prefix_r;
    found_nxt  = found_r;
    if (cmd.load || cmd.clear || (cmd.scan && cmd.last)) begin
      prefix_nxt = '0;
      found_nxt  = '0;
    end else if (cmd.scan) begin
      prefix_nxt = prefix_scan;
      found_nxt  = found_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      found_r  <= '0;
    end else begin
      prefix_r <= prefix_nxt;
      found_r  <= found_nxt;
    end
  end

endmodule

// File: rtl/core/multi_term_substring_filter_top.sv
// ----------------------------------------------------------------------------
// multi_term_substring_filter_top: multi-term substring filter
// Case-insensitive multi-term substring filter with AND/OR combining.
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle while in_stall is low; in_stall
// rises only while out_stall holds a pending result. A transaction passes
// through the input register, and a result through the result register. Each
// text byte is compared against all stored term positions at once. A filter
// transaction adds to the terms, a clear transaction empties them, and a
// text transaction with the end flag set yields one result transaction.
// No initialization pass follows reset.
module multi_term_substring_filter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_byte_value,
  input  logic                        in_end_flag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_matched,
  output logic                        out_filter_overflow,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtsf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [1:0]                  s1_kind_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_end_r;
  logic                        in_accept;
  logic                        out_blocked;
  logic                        advance;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_matched_r;
  logic                        out_overflow_r;
  logic                        res_en;
  logic                        matched;
  logic                        overflow;
  mtsf_pkg::step_cmd_t         cmd;
  mtsf_pkg::cfg_t              cfg;
  mtsf_pkg::term_store_t       term_bytes;
  mtsf_pkg::term_len_t         term_len;
  logic [mtsf_pkg::TOT_W-1:0]  term_total;

  assign out_blocked  = out_valid_r && out_stall;
  assign advance      = s1_valid_r && !out_blocked;
  assign in_stall     = s1_valid_r && out_blocked;
  assign in_accept    = in_valid && !in_stall;
  assign s1_valid_nxt = in_stall ? 1'b1 : in_valid;

  always_comb begin
    cmd       = '0;
    cmd.data  = s1_byte_r;
    cmd.last  = s1_end_r;
    if (advance) begin
      case (s1_kind_r)
        mtsf_pkg::KIND_FILTER: cmd.load  = 1'b1;
        mtsf_pkg::KIND_TEXT:   cmd.scan  = 1'b1;
        mtsf_pkg::KIND_CLEAR:  cmd.clear = 1'b1;
        default:               cmd.load  = 1'b0;
      endcase
    end
  end

  assign res_en        = cmd.scan && cmd.last;
  assign out_valid_nxt = out_blocked ? 1'b1 : res_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_byte_value;
      s1_end_r  <= in_end_flag;
    end
    if (res_en) begin
      out_matched_r  <= matched;
      out_overflow_r <= overflow;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_matched         = out_matched_r;
  assign out_filter_overflow = out_overflow_r;

  mtsf_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtsf_loader u_loader (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .term_bytes (term_bytes),
    .term_len   (term_len),
    .term_total (term_total),
    .overflow   (overflow)
  );

  mtsf_matcher u_matcher (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .term_bytes (term_bytes),
    .term_len   (term_len),
    .term_total (term_total),
    .matched    (matched)
  );

endmodule
